// ===== rtl/mqjd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqjd_pkg
// Shared types and codes for the multi-queue job dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mqjd_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;

    localparam logic [3:0] NUM_CPUS_RST    = 4'd2;
    localparam logic [1:0] ASSIGN_MODE_RST = 2'd1;
    localparam logic       PICK_POLICY_RST = 1'b0;

    localparam logic [1:0] CFG_NUM_CPUS    = 2'd0;
    localparam logic [1:0] CFG_ASSIGN_MODE = 2'd1;
    localparam logic [1:0] CFG_PICK_POLICY = 2'd2;

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_MODULO = 2'd1;
    localparam logic [1:0] MODE_LEAST  = 2'd2;

    localparam logic POL_FIFO     = 1'b0;
    localparam logic POL_SHORTEST = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] len;
        logic [ID_W-1:0] arr;
    } job_t;

    typedef struct packed {
        logic vld;
        job_t job;
    } carry_t;

    typedef struct packed {
        logic active;
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mqjd_req_if.sv =====
// ----------------------------------------------------------------------------
// mqjd_req_if
// Request channel: submit and dispatch words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqjd_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] job_id;
    logic [15:0] job_length;
    logic [15:0] arrival_stamp;
    logic [2:0]  cpu_index;

    modport source (output valid, opcode, job_id, job_length, arrival_stamp, cpu_index,
                    input ready);
    modport sink (input valid, opcode, job_id, job_length, arrival_stamp, cpu_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/mqjd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mqjd_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqjd_rsp_if;
    logic        valid;
    logic        ready;
    logic        op_echo;
    logic [1:0]  status;
    logic [2:0]  queue_index;
    logic [15:0] out_job_id;
    logic [15:0] out_job_length;
    logic [15:0] out_arrival;
    logic [4:0]  queue_fill;

    modport source (output valid, op_echo, status, queue_index, out_job_id,
                    out_job_length, out_arrival, queue_fill, input ready);
    modport sink (input valid, op_echo, status, queue_index, out_job_id,
                  out_job_length, out_arrival, queue_fill, output ready);
endinterface

`default_nettype wire

// ===== rtl/mqjd_cell.sv =====
// ----------------------------------------------------------------------------
// mqjd_cell
// One queue slot: holds a job, shifts down from its neighbor on removal and
// forwards the running shortest job of the slots below it.
// ----------------------------------------------------------------------------
`default_nettype none

module mqjd_cell
    import mqjd_pkg::*;
#(
    parameter int PW    = 4,
    parameter int INDEX = 0
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctl_t     ctl,
    input  wire job_t          wr_job,
    input  wire job_t          nxt_job,
    input  wire carry_t        prv_carry,
    input  wire logic [PW-1:0] prv_idx,
    output job_t               job,
    output carry_t             carry,
    output logic [PW-1:0]      idx
);

    job_t            job_reg;
    carry_t          carry_reg;
    logic [PW-1:0]   idx_reg;
    logic            take_own;

    // Strict compare keeps the older job on equal lengths.
    assign take_own = ctl.active && (!prv_carry.vld || job_reg.len < prv_carry.job.len);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            job_reg <= wr_job;
        end
        else if (ctl.shift)
        begin
            job_reg <= nxt_job;
        end
        idx_reg <= take_own ? PW'(INDEX) : prv_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else if (take_own)
        begin
            carry_reg <= {1'b1, job_reg};
        end
        else
        begin
            carry_reg <= prv_carry;
        end
    end

    assign job   = job_reg;
    assign carry = carry_reg;
    assign idx   = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/mqjd_modu.sv =====
// ----------------------------------------------------------------------------
// mqjd_modu
// Bit-serial remainder of a job id by the processor count.
// ----------------------------------------------------------------------------
`default_nettype none

module mqjd_modu
    import mqjd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [ID_W-1:0] dividend,
    input  wire logic [3:0]      divisor,
    output logic                 done,
    output logic [3:0]           rem
);

    localparam int CNTW = $clog2(ID_W + 1);

    logic [ID_W-1:0] dvd_reg;
    logic [3:0]      div_reg;
    logic [3:0]      rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [4:0]      trial;
    logic [4:0]      rem_next;

    assign trial    = {rem_reg, dvd_reg[ID_W-1]};
    assign rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(ID_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ID_W-2:0], 1'b0};
            rem_reg <= rem_next[3:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/multi_queue_job_dispatcher.sv =====
// ----------------------------------------------------------------------------
// multi_queue_job_dispatcher
// Per-processor ready queues with FIFO or shortest-first dispatch.
// ----------------------------------------------------------------------------
// Each queue is a row of slot cells, oldest job in slot 0. A submit placed
// by id modulo first waits for the serial remainder unit; one placed on the
// least-filled queue first scans the queues, one queue compared per cycle.
// A dispatch in shortest-first mode first waits while the running minimum
// travels along the row of cells. One word is in flight at a time; the
// next request is accepted while the previous result waits at the output.
`default_nettype none

module multi_queue_job_dispatcher
    import mqjd_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_wdata,
    mqjd_req_if.sink        req,
    mqjd_rsp_if.source      rsp
);

    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_SCAN, S_PLACE, S_WAIT, S_EXEC, S_DONE
    } state_t;

    state_t          state_reg;
    logic [3:0]      num_cpus_reg;
    logic [1:0]      assign_mode_reg;
    logic            pick_policy_reg;
    logic [CW-1:0]   count_reg [NUM_QUEUES];
    logic [3:0]      qsel_reg;
    logic [3:0]      scan_reg;
    logic [PW:0]     wait_reg;
    job_t            in_job_reg;
    logic            op_reg;
    logic [1:0]      res_status_reg;
    job_t            res_job_reg;
    logic [4:0]      res_fill_reg;

    logic            rsp_valid_reg;
    logic            rsp_op_reg;
    logic [1:0]      rsp_status_reg;
    logic [2:0]      rsp_qidx_reg;
    job_t            rsp_job_reg;
    logic [4:0]      rsp_fill_reg;

    job_t            cell_job   [NUM_QUEUES][QUEUE_DEPTH];
    carry_t          cell_carry [NUM_QUEUES][QUEUE_DEPTH];
    logic [PW-1:0]   cell_idx   [NUM_QUEUES][QUEUE_DEPTH];

    logic [3:0]      cpus_tmp;
    logic [3:0]      n_use;
    logic [QIW-1:0]  qsel_q;
    logic [QIW-1:0]  cpu_q;
    logic [CW-1:0]   count_sel;
    logic            place_full;
    logic            cpu_out;
    logic            accept;
    logic            mod_done;
    logic [3:0]      mod_rem;
    logic [PW-1:0]   pick;
    job_t            got_job;
    logic [15:0]     fill_wide;

    assign cpus_tmp   = (num_cpus_reg == 4'd0) ? 4'd1 : num_cpus_reg;
    assign n_use      = (5'(cpus_tmp) > 5'(NUM_QUEUES)) ? 4'(NUM_QUEUES) : cpus_tmp;
    assign qsel_q     = qsel_reg[QIW-1:0];
    assign cpu_q      = QIW'(req.cpu_index);
    assign count_sel  = count_reg[qsel_q];
    assign place_full = (count_sel >= CW'(QUEUE_DEPTH));
    assign cpu_out    = ({2'b00, req.cpu_index} >= 5'(NUM_QUEUES));
    assign accept     = req.valid && (state_reg == S_IDLE);
    assign req.ready  = (state_reg == S_IDLE);

    assign pick    = (pick_policy_reg == POL_SHORTEST) ? cell_idx[qsel_q][QUEUE_DEPTH-1] : '0;
    assign got_job = (pick_policy_reg == POL_SHORTEST) ? cell_carry[qsel_q][QUEUE_DEPTH-1].job
                                                       : cell_job[qsel_q][0];

    mqjd_modu u_modu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && req.opcode == OP_SUBMIT && assign_mode_reg == MODE_MODULO),
        .dividend (req.job_id),
        .divisor  (n_use),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    for (genvar r = 0; r < NUM_QUEUES; r++)
    begin : g_row
        for (genvar i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            cell_ctl_t      ctl;
            job_t           nxt;
            carry_t         prv;
            logic [PW-1:0]  prv_i;

            assign ctl.active = (CW'(i) < count_reg[r]);
            assign ctl.load   = (state_reg == S_PLACE) && !place_full &&
                                (qsel_q == QIW'(r)) && (count_sel == CW'(i));
            assign ctl.shift  = (state_reg == S_EXEC) && (qsel_q == QIW'(r)) &&
                                ({1'b0, pick} <= (PW+1)'(i)) && (CW'(i + 1) < count_sel);

            if (i == 0)
            begin : g_first
                assign prv   = '0;
                assign prv_i = '0;
            end
            else
            begin : g_mid
                assign prv   = cell_carry[r][i-1];
                assign prv_i = cell_idx[r][i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign nxt = '0;
            end
            else
            begin : g_inner
                assign nxt = cell_job[r][i+1];
            end

            mqjd_cell #(.PW(PW), .INDEX(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .wr_job    (in_job_reg),
                .nxt_job   (nxt),
                .prv_carry (prv),
                .prv_idx   (prv_i),
                .job       (cell_job[r][i]),
                .carry     (cell_carry[r][i]),
                .idx       (cell_idx[r][i])
            );
        end
    end

    always_comb
    begin
        fill_wide = 16'(count_sel);
        if (state_reg == S_PLACE && !place_full)
        begin
            fill_wide = 16'(count_sel) + 16'd1;
        end
        else if (state_reg == S_EXEC)
        begin
            fill_wide = 16'(count_sel) - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_cpus_reg    <= NUM_CPUS_RST;
            assign_mode_reg <= ASSIGN_MODE_RST;
            pick_policy_reg <= PICK_POLICY_RST;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                count_reg[k] <= '0;
            end
            rsp_valid_reg <= 1'b0;
            qsel_reg      <= '0;
            scan_reg      <= '0;
            wait_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_CPUS:    num_cpus_reg    <= cfg_wdata;
                    CFG_ASSIGN_MODE: assign_mode_reg <= cfg_wdata[1:0];
                    CFG_PICK_POLICY: pick_policy_reg <= cfg_wdata[0];
                    default:         ;
                endcase
            end

            // In S_DONE the output register is reloaded below instead.
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= req.opcode;
                        in_job_reg     <= '{id: req.job_id, len: req.job_length,
                                            arr: req.arrival_stamp};
                        res_job_reg    <= '0;
                        if (req.opcode == OP_SUBMIT)
                        begin
                            qsel_reg <= '0;
                            scan_reg <= 4'd1;
                            case (assign_mode_reg)
                                MODE_MODULO: state_reg <= S_MOD;
                                MODE_LEAST:  state_reg <= S_SCAN;
                                default:     state_reg <= S_PLACE;
                            endcase
                        end
                        else
                        begin
                            qsel_reg <= {1'b0, req.cpu_index};
                            wait_reg <= '0;
                            if (cpu_out || count_reg[cpu_q] == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                res_fill_reg   <= '0;
                                state_reg      <= S_DONE;
                            end
                            else if (pick_policy_reg == POL_SHORTEST)
                            begin
                                state_reg <= S_WAIT;
                            end
                            else
                            begin
                                state_reg <= S_EXEC;
                            end
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        qsel_reg  <= mod_rem;
                        state_reg <= S_PLACE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg >= n_use)
                    begin
                        state_reg <= S_PLACE;
                    end
                    else
                    begin
                        if (count_reg[scan_reg[QIW-1:0]] < count_sel)
                        begin
                            qsel_reg <= scan_reg;
                        end
                        scan_reg <= scan_reg + 4'd1;
                    end
                end
                S_PLACE:
                begin
                    if (place_full)
                    begin
                        res_status_reg <= ST_FULL;
                    end
                    else
                    begin
                        res_status_reg    <= ST_OK;
                        count_reg[qsel_q] <= count_sel + 1'b1;
                    end
                    res_fill_reg <= fill_wide[4:0];
                    state_reg    <= S_DONE;
                end
                S_WAIT:
                begin
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == (PW+1)'(QUEUE_DEPTH))
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_status_reg    <= ST_OK;
                    res_job_reg       <= got_job;
                    res_fill_reg      <= fill_wide[4:0];
                    count_reg[qsel_q] <= count_sel - 1'b1;
                    state_reg         <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_op_reg     <= op_reg;
                        rsp_status_reg <= res_status_reg;
                        rsp_qidx_reg   <= qsel_reg[2:0];
                        rsp_job_reg    <= res_job_reg;
                        rsp_fill_reg   <= res_fill_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.op_echo        = rsp_op_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.queue_index    = rsp_qidx_reg;
    assign rsp.out_job_id     = rsp_job_reg.id;
    assign rsp.out_job_length = rsp_job_reg.len;
    assign rsp.out_arrival    = rsp_job_reg.arr;
    assign rsp.queue_fill     = rsp_fill_reg;

`ifndef SYNTHESIS
    // A removal only happens from a queue that holds the picked slot.
    a_exec_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ((CW'(pick) < count_sel) && (count_sel != '0)))
        else $error("dispatch picks a slot beyond the queue fill");

    // A finished word reaches the output register and frees the input once the output register is free.
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rsp_valid_reg || rsp.ready))
        |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("result not handed to the output register");

    // The modulo placement never selects a queue beyond the processor count.
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && mod_done) |-> (mod_rem < n_use))
        else $error("modulo placement out of range");
`endif

endmodule

`default_nettype wire
